// ===== hw/rtl/u8dec_pkg.sv =====
// Package for the UTF-8 byte stream decoder: request types, decoder state
// and the byte-class constants. No dependencies.
`default_nettype none

package u8dec_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

	// lead byte patterns, compared against the top bits of the byte
	localparam logic [2:0] Lead2Pat = 3'b110;
	localparam logic [3:0] Lead3Pat = 4'b1110;
	localparam logic [4:0] Lead4Pat = 5'b11110;
	localparam logic [1:0] ContPat  = 2'b10;

	// continuation bytes still expected; zero means idle
	localparam logic [1:0] LeftIdle = 2'd0;
	localparam logic [1:0] LeftOne  = 2'd1;
	localparam logic [1:0] LeftTwo  = 2'd2;
	localparam logic [1:0] LeftThree = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       source_end;
	} byte_item_t;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic               malformed;
		logic               truncated;
	} cp_item_t;

	typedef struct packed {
		logic [CpWidth-1:0] partial_value;
		logic [1:0]         bytes_left;
	} dec_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/u8dec_step.sv =====
// One decode step: current state plus one byte gives the next state and
// at most one code point. Pure combinational. Depends on u8dec_pkg.
`default_nettype none

module u8dec_step (
	input  wire u8dec_pkg::dec_state_t  cur,
	input  wire u8dec_pkg::byte_item_t  item,
	output u8dec_pkg::dec_state_t       nxt,
	output logic                        emit,
	output u8dec_pkg::cp_item_t         result
);

	logic [7:0]                      b;
	logic [u8dec_pkg::CpWidth-1:0]   shifted;
	logic [1:0]                      left_dec;

	assign b        = item.data_byte;
	assign shifted  = {cur.partial_value[u8dec_pkg::CpWidth-7:0], b[5:0]};
	assign left_dec = cur.bytes_left - 2'd1;

	always_comb begin
		nxt    = cur;
		emit   = 1'b0;
		result = '{code_point: '0, malformed: 1'b0, truncated: 1'b0};
		if (cur.bytes_left == u8dec_pkg::LeftIdle) begin
			priority if (!b[7]) begin
				emit              = 1'b1;
				result.code_point = {13'd0, b};
			end else if (b[7:5] == u8dec_pkg::Lead2Pat) begin
				nxt.partial_value = {16'd0, b[4:0]};
				nxt.bytes_left    = u8dec_pkg::LeftOne;
			end else if (b[7:4] == u8dec_pkg::Lead3Pat) begin
				nxt.partial_value = {17'd0, b[3:0]};
				nxt.bytes_left    = u8dec_pkg::LeftTwo;
			end else if (b[7:3] == u8dec_pkg::Lead4Pat) begin
				nxt.partial_value = {18'd0, b[2:0]};
				nxt.bytes_left    = u8dec_pkg::LeftThree;
			end else begin
				emit              = 1'b1;
				result.code_point = u8dec_pkg::Replacement;
				result.malformed  = 1'b1;
			end
			// lead byte that is also the last byte of the source
			if (nxt.bytes_left != u8dec_pkg::LeftIdle && item.source_end) begin
				nxt.bytes_left    = u8dec_pkg::LeftIdle;
				emit              = 1'b1;
				result.code_point = nxt.partial_value;
				result.truncated  = 1'b1;
			end
		end else if (b[7:6] != u8dec_pkg::ContPat) begin
			// bad continuation is swallowed, not reparsed
			nxt.bytes_left    = u8dec_pkg::LeftIdle;
			nxt.partial_value = '0;
			emit              = 1'b1;
			result.code_point = u8dec_pkg::Replacement;
			result.malformed  = 1'b1;
		end else begin
			nxt.partial_value = shifted;
			nxt.bytes_left    = left_dec;
			if (left_dec == u8dec_pkg::LeftIdle) begin
				emit              = 1'b1;
				result.code_point = shifted;
			end else if (item.source_end) begin
				nxt.bytes_left    = u8dec_pkg::LeftIdle;
				emit              = 1'b1;
				result.code_point = shifted;
				result.truncated  = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_byte_stream_decoder.sv =====
// Lenient UTF-8 byte stream decoder, top level: input register, decode step,
// decoder state and result register. Depends on u8dec_pkg and u8dec_step.
//
// Usage:
//   Byte channel (byte_valid / byte_stall / byte_item) takes one source byte
//   per request, with source_end set on the last byte of the source.
//   Code point channel (cp_valid / cp_stall / cp_item) gives zero or one
//   code point per byte: a finished character, U+FFFD with malformed set on
//   a bad byte, or the partial value with truncated set when the source
//   ends inside a sequence.
//   A byte accepted goes into the input register and is decoded from there;
//   its result is loaded into the result register, where cp_valid shows it.
//   Throughput: one byte per cycle while no byte with a result waits on a
//   stalled output; the decode step updates the partial value and bytes left.
//   A stalled result holds in the result register; the byte in the input
//   register waits there, and byte_stall rises only once both are full.
//   Bytes that emit nothing keep moving even while the output is stalled.
//   Reset clears both valid flags and returns the decoder to idle.
`default_nettype none

module utf8_byte_stream_decoder (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       byte_valid,
	output logic                      byte_stall,
	input  wire u8dec_pkg::byte_item_t byte_item,
	output logic                      cp_valid,
	input  wire                       cp_stall,
	output u8dec_pkg::cp_item_t       cp_item
);

	logic                    valid_s1;
	u8dec_pkg::byte_item_t   item_s1;
	u8dec_pkg::dec_state_t   state_q;
	u8dec_pkg::dec_state_t   state_nxt;
	logic                    emit;
	u8dec_pkg::cp_item_t     result;
	logic                    out_free;
	logic                    step;
	logic                    take_in;

	u8dec_step u_step (
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.emit   (emit),
		.result (result)
	);

	assign out_free   = !cp_valid || !cp_stall;
	// a byte with no result never needs the output register
	assign step       = valid_s1 && (out_free || !emit);
	assign byte_stall = valid_s1 && !step;
	assign take_in    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cp_valid <= 1'b0;
			state_q  <= '{partial_value: '0, bytes_left: u8dec_pkg::LeftIdle};
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				state_q <= state_nxt;
			end
			if (step && emit) begin
				cp_valid <= 1'b1;
			end else if (!cp_stall) begin
				cp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= byte_item;
		end
		if (step && emit) begin
			cp_item <= result;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/u8dec_checker.sv =====
// Port-level checks for the UTF-8 decoder, bound to the top level.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        cp_valid,
	input wire                        cp_stall,
	input wire u8dec_pkg::cp_item_t   cp_item
);

	// flags are exclusive
	assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid |-> !(cp_item.malformed && cp_item.truncated))
		else $error("malformed and truncated both set");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && cp_item.malformed) |-> (cp_item.code_point == u8dec_pkg::Replacement))
		else $error("malformed without replacement character");

	// a cut-short sequence holds at most 15 payload bits
	assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && cp_item.truncated) |-> (cp_item.code_point[20:15] == 6'd0))
		else $error("truncated value too wide");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && cp_stall) |=> (cp_valid && $stable(cp_item)))
		else $error("stalled request changed");

endmodule

bind utf8_byte_stream_decoder u8dec_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cp_valid (cp_valid),
	.cp_stall (cp_stall),
	.cp_item  (cp_item)
);

`default_nettype wire
